// ----- rtl/assert_macros.svh -----
// Assertion macros used by the glyph unpacker RTL.
// Needs nothing else; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define GBAU_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbau same-cycle check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define GBAU_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbau next-cycle check failed");

`endif

// ----- rtl/gbau_pkg.sv -----
// Shared types, constants and helpers of the glyph bitmap alpha unpacker.
// No dependencies; every RTL module imports it.
package gbau_pkg;

    localparam int LANES  = 8;
    localparam int LANE_W = 3;
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [7:0] CODE_MASK_2 = 8'h03;
    localparam logic [7:0] CODE_MASK_4 = 8'h0F;
    localparam logic [7:0] FULL_ALPHA  = 8'hFF;

    typedef enum logic [1:0] {
        MODE_1BPP,
        MODE_2BPP,
        MODE_4BPP,
        MODE_8BPP
    } t_mode;

    typedef enum logic [2:0] {
        REG_BIT_MODE,
        REG_GLYPH_BOX,
        REG_GLYPH_ALPHA,
        REG_MAP_2BIT,
        REG_MAP_4BIT_LO,
        REG_MAP_4BIT_HI,
        REG_ORIGIN_X,
        REG_ORIGIN_Y
    } t_reg_idx;

    typedef struct packed {
        t_mode        bit_mode;
        logic [7:0]   box_w;
        logic [7:0]   box_h;
        logic [7:0]   glyph_alpha;
        logic [31:0]  map2;
        logic [63:0]  map4_lo;
        logic [63:0]  map4_hi;
        logic [15:0]  origin_x;
        logic [15:0]  origin_y;
    } t_cfg;

    typedef struct packed {
        logic [15:0] x;
        logic [7:0]  alpha;
        logic        last;
        logic        done;
    } t_lane_res;

    // floor(v / 255), exact for any product of two bytes
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] s;
        s = {1'b0, v} + {9'b0, v[15:8]} + 17'd1;
        return s[15:8];
    endfunction

    // index of the last pixel slot of a byte in the given mode
    function automatic logic [LANE_W-1:0] last_slot(input t_mode m);
        logic [LANE_W-1:0] r;
        unique case (m)
            MODE_1BPP: r = 3'd7;
            MODE_2BPP: r = 3'd3;
            MODE_4BPP: r = 3'd1;
            MODE_8BPP: r = 3'd0;
            default:   r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/gbau_regs.sv -----
// APB register file holding the unpacker settings.
// Depends on gbau_pkg.
module gbau_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gbau_pkg::ADDR_W-1:0] paddr,
    input  logic [gbau_pkg::DATA_W-1:0] pwdata,
    output logic [gbau_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output gbau_pkg::t_cfg              o_cfg
);
    import gbau_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_sel;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{bit_mode: MODE_1BPP, glyph_alpha: FULL_ALPHA, default: '0};
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_BIT_MODE:    r_cfg.bit_mode    <= t_mode'(pwdata[1:0]);
                REG_GLYPH_BOX: begin
                    r_cfg.box_w <= pwdata[7:0];
                    r_cfg.box_h <= pwdata[15:8];
                end
                REG_GLYPH_ALPHA: r_cfg.glyph_alpha <= pwdata[7:0];
                REG_MAP_2BIT:    r_cfg.map2        <= pwdata[31:0];
                REG_MAP_4BIT_LO: r_cfg.map4_lo     <= pwdata;
                REG_MAP_4BIT_HI: r_cfg.map4_hi     <= pwdata;
                REG_ORIGIN_X:    r_cfg.origin_x    <= pwdata[15:0];
                REG_ORIGIN_Y:    r_cfg.origin_y    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_BIT_MODE:    prdata = {62'b0, r_cfg.bit_mode};
            REG_GLYPH_BOX:   prdata = {48'b0, r_cfg.box_h, r_cfg.box_w};
            REG_GLYPH_ALPHA: prdata = {56'b0, r_cfg.glyph_alpha};
            REG_MAP_2BIT:    prdata = {32'b0, r_cfg.map2};
            REG_MAP_4BIT_LO: prdata = r_cfg.map4_lo;
            REG_MAP_4BIT_HI: prdata = r_cfg.map4_hi;
            REG_ORIGIN_X:    prdata = {48'b0, r_cfg.origin_x};
            REG_ORIGIN_Y:    prdata = {48'b0, r_cfg.origin_y};
            default:         prdata = '0;
        endcase
    end

endmodule

// ----- rtl/gbau_lane.sv -----
// One pixel lane: extracts the code of its slot, maps and scales the alpha,
// and forms the column and flags. Depends on gbau_pkg.
module gbau_lane (
    input  gbau_pkg::t_cfg                  i_cfg,
    input  logic [7:0]                      i_byte,
    input  logic [gbau_pkg::LANE_W-1:0]     i_lane,
    input  logic [7:0]                      i_col0,
    input  logic                            i_row_end,
    input  logic [gbau_pkg::LANE_W-1:0]     i_last_idx,
    output gbau_pkg::t_lane_res             o_res
);
    import gbau_pkg::*;

    logic [5:0]  shamt;
    logic [7:0]  raw;
    logic [7:0]  code;
    logic [7:0]  entry;
    logic [15:0] prod;
    logic [8:0]  col;

    always_comb begin
        shamt = {3'b0, i_lane} << i_cfg.bit_mode;
        raw   = i_byte >> shamt;
        case (i_cfg.bit_mode)
            MODE_1BPP: code = {7'b0, raw[0]};
            MODE_2BPP: code = raw & CODE_MASK_2;
            MODE_4BPP: code = raw & CODE_MASK_4;
            default:   code = raw;
        endcase

        case (i_cfg.bit_mode)
            MODE_1BPP: entry = i_cfg.glyph_alpha;
            MODE_2BPP: entry = i_cfg.map2[{code[1:0], 3'b000} +: 8];
            MODE_4BPP: entry = code[3] ? i_cfg.map4_hi[{code[2:0], 3'b000} +: 8]
                                       : i_cfg.map4_lo[{code[2:0], 3'b000} +: 8];
            default:   entry = code;
        endcase

        prod = {8'b0, entry} * {8'b0, i_cfg.glyph_alpha};

        if (code == 8'd0) begin
            o_res.alpha = 8'd0;
        end else if (i_cfg.bit_mode == MODE_1BPP) begin
            o_res.alpha = i_cfg.glyph_alpha;
        end else begin
            o_res.alpha = div255(prod);
        end

        col        = {1'b0, i_col0} + {6'b0, i_lane};
        o_res.x    = i_cfg.origin_x + {8'b0, i_col0} + {13'b0, i_lane};
        o_res.done = i_row_end && (col == ({1'b0, i_cfg.box_w} - 9'd1));
        o_res.last = (i_lane == i_last_idx);
    end

endmodule

// ----- rtl/gbau_merge.sv -----
// Lane bank and output stage: holds one byte's lane results and hands them
// out one word per cycle, while the output is not stalled, through the output register. Depends on gbau_pkg.
module gbau_merge (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_load,
    input  gbau_pkg::t_lane_res [gbau_pkg::LANES-1:0] i_res,
    input  logic [15:0]                             i_y,
    input  logic [gbau_pkg::LANE_W-1:0]             i_last_idx,
    output logic                                    o_free,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [15:0]                             o_pixel_x,
    output logic [15:0]                             o_pixel_y,
    output logic [7:0]                              o_cover_alpha,
    output logic                                    o_last_of_byte,
    output logic                                    o_glyph_done
);
    import gbau_pkg::*;

    t_lane_res [LANES-1:0] r_res;
    logic [15:0]           r_y;
    logic [LANE_W-1:0]     r_last_idx;
    logic [LANE_W-1:0]     r_idx;
    logic                  r_full;
    logic                  r_out_valid;
    t_lane_res             r_out;
    logic [15:0]           r_out_y;

    logic out_free;
    logic move;
    logic drain_last;

    always_comb begin
        out_free   = !r_out_valid || !i_stall;
        move       = r_full && out_free;
        drain_last = move && (r_idx == r_last_idx);
        o_free     = !r_full || drain_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_full <= 1'b1;
                r_idx  <= '0;
            end else if (drain_last) begin
                r_full <= 1'b0;
            end else if (move) begin
                r_idx <= r_idx + 3'd1;
            end

            if (move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res      <= i_res;
            r_y        <= i_y;
            r_last_idx <= i_last_idx;
        end
        if (move) begin
            r_out   <= r_res[r_idx];
            r_out_y <= r_y;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pixel_x      = r_out.x;
    assign o_pixel_y      = r_out_y;
    assign o_cover_alpha  = r_out.alpha;
    assign o_last_of_byte = r_out.last;
    assign o_glyph_done   = r_out.done;

endmodule

// ----- rtl/glyph_bitmap_alpha_unpacker_core.sv -----
// Top level of the glyph bitmap alpha unpacker.
// Depends on gbau_pkg, gbau_regs, gbau_lane, gbau_merge, assert_macros.svh.
//
// Usage:
//   Input channel (i_valid / o_stall / i_data_byte) takes one packed pixel
//   word per accepted edge. Output channel (o_valid / i_stall / o_pixel_x,
//   o_pixel_y, o_cover_alpha and the two flags) delivers one pixel word per
//   accepted edge, in scan order.
//   Settings must be written through the APB port while the block is idle; it is not enforced.
//   The accept edge loads a word into the lane bank; its first pixel then
//   moves into the output register, which drives o_valid, unless a stall
//   on the output holds it in the bank.
//   Throughput: eight lanes decode a whole word combinationally; the bank then
//   drains one pixel per cycle while the output is not stalled, so a word
//   emits up to 8 pixels at 1 bpp, 4, 2 and 1 in the wider modes. The next word
//   is accepted on the cycle the last pixel of the previous one moves out.
//   Words arriving while the glyph box is empty are taken and dropped.
//   Stall: while i_stall is high the output word holds; the bank fills and
//   o_stall rises until the output moves again.
//   Reset (synchronous, active low) empties the bank and the output register,
//   clears the row and column counters and restores every setting to default.
`include "assert_macros.svh"

module glyph_bitmap_alpha_unpacker_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gbau_pkg::ADDR_W-1:0] paddr,
    input  logic [gbau_pkg::DATA_W-1:0] pwdata,
    output logic [gbau_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_data_byte,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [15:0]          o_pixel_x,
    output logic signed [15:0]          o_pixel_y,
    output logic [7:0]                  o_cover_alpha,
    output logic                        o_last_of_byte,
    output logic                        o_glyph_done
);
    import gbau_pkg::*;

    t_cfg                  cfg;
    t_lane_res [LANES-1:0] lane_res;

    logic [7:0]        r_col;
    logic [7:0]        r_row;
    logic [7:0]        n_col;
    logic [7:0]        n_row;

    logic              box_empty;
    logic              stale;
    logic [7:0]        col0;
    logic [7:0]        row0;
    logic              row_end;
    logic [7:0]        rem_m1;
    logic [LANE_W-1:0] slot_last;
    logic [LANE_W-1:0] last_idx;
    logic [15:0]       pix_y;
    logic              bank_free;
    logic              accept;
    logic              load;
    logic [15:0]       out_x;
    logic [15:0]       out_y;

    gbau_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Restart at the box corner when the box shrank under the counters.
    always_comb begin
        box_empty = (cfg.box_w == 8'd0) || (cfg.box_h == 8'd0);
        stale     = (r_col >= cfg.box_w) || (r_row >= cfg.box_h);
        col0      = stale ? 8'd0 : r_col;
        row0      = stale ? 8'd0 : r_row;
        row_end   = (row0 == cfg.box_h - 8'd1);
        pix_y     = cfg.origin_y + {8'b0, row0};

        // pixels this word emits: the smaller of the slot count and what is
        // left of the row
        rem_m1    = cfg.box_w - col0 - 8'd1;
        slot_last = last_slot(cfg.bit_mode);
        last_idx  = (rem_m1 < {5'b0, slot_last}) ? rem_m1[LANE_W-1:0] : slot_last;

        // advance the counters; wrap the row at the bottom of the box
        if (rem_m1 == {5'b0, last_idx}) begin
            n_col = 8'd0;
            n_row = row_end ? 8'd0 : row0 + 8'd1;
        end else begin
            n_col = col0 + {5'b0, last_idx} + 8'd1;
            n_row = row0;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        gbau_lane u_lane (
            .i_cfg      (cfg),
            .i_byte     (i_data_byte),
            .i_lane     (LANE_W'(g)),
            .i_col0     (col0),
            .i_row_end  (row_end),
            .i_last_idx (last_idx),
            .o_res      (lane_res[g])
        );
    end

    // Take a word whenever the bank is empty or emptying this cycle.
    assign o_stall = !bank_free;
    assign accept  = i_valid && !o_stall;
    assign load    = accept && !box_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (load) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    gbau_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (load),
        .i_res          (lane_res),
        .i_y            (pix_y),
        .i_last_idx     (last_idx),
        .o_free         (bank_free),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_x      (out_x),
        .o_pixel_y      (out_y),
        .o_cover_alpha  (o_cover_alpha),
        .o_last_of_byte (o_last_of_byte),
        .o_glyph_done   (o_glyph_done)
    );

    assign o_pixel_x = $signed(out_x);
    assign o_pixel_y = $signed(out_y);

    // The corner pixel always closes its word.
    `GBAU_ASSERT_IMP(a_done_is_last, i_clk, i_rst_n, o_valid && o_glyph_done, o_last_of_byte)
    // After a decoded word the counters sit inside the box.
    `GBAU_ASSERT_NXT(a_cnt_in_box, i_clk, i_rst_n, load, (r_col < $past(cfg.box_w)) && (r_row < $past(cfg.box_h)))
    // A word taken with an empty box leaves the counters alone.
    `GBAU_ASSERT_NXT(a_empty_hold, i_clk, i_rst_n, accept && box_empty, (r_col == $past(r_col)) && (r_row == $past(r_row)))

endmodule
